// ===== design/s2c_pkg.sv =====
// Shared types, constants and the arctangent table for the spherical to
// Cartesian converter. No dependencies.
package s2c_pkg;

    // Angle format: degrees with 16 fraction bits
    localparam int ANG_W   = 26;
    localparam int MOD_W   = 25;                    // wrapped angle, [0, 360)
    localparam int ZW      = 24;                    // CORDIC residual angle
    localparam int XW      = 34;                    // CORDIC x/y, Q30 plus headroom
    localparam int RAD_W   = 32;
    localparam int COORD_W = 32;
    localparam int LAT_W   = 36;                    // first product after rounding
    localparam int P1_W    = RAD_W + XW;            // radius times trig term
    localparam int P2_W    = LAT_W + XW;            // lateral term times trig term
    localparam int PR_W    = P2_W - 30;             // second product after rounding

    localparam logic signed [ANG_W:0] ANG_FULL    = 27'sd23592960;
    localparam logic [MOD_W-1:0]      ANG_QUARTER = 25'd5898240;
    localparam logic [MOD_W-1:0]      ANG_HALF    = 25'd11796480;
    localparam logic [MOD_W-1:0]      ANG_3QUART  = 25'd17694720;
    localparam logic [MOD_W-1:0]      ANG_EIGHTH  = 25'd2949120;

    localparam logic signed [XW-1:0]  CORDIC_GAIN = 34'sd652032874;

    typedef enum logic [0:0] {
        CONV_AZEL  = 1'b0,
        CONV_POLAR = 1'b1
    } conv_t;

    // atan(2^-i) in degrees, 16 fraction bits
    function automatic logic signed [ZW-1:0] atan_deg(input int idx);
        logic signed [ZW-1:0] v;
        case (idx)
            0:  v = 24'sd2949120;
            1:  v = 24'sd1740967;
            2:  v = 24'sd919879;
            3:  v = 24'sd466945;
            4:  v = 24'sd234379;
            5:  v = 24'sd117304;
            6:  v = 24'sd58666;
            7:  v = 24'sd29335;
            8:  v = 24'sd14668;
            9:  v = 24'sd7334;
            10: v = 24'sd3667;
            11: v = 24'sd1833;
            12: v = 24'sd917;
            13: v = 24'sd458;
            14: v = 24'sd229;
            15: v = 24'sd115;
            16: v = 24'sd57;
            17: v = 24'sd29;
            18: v = 24'sd14;
            19: v = 24'sd7;
            20: v = 24'sd4;
            21: v = 24'sd2;
            22: v = 24'sd1;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== design/s2c_cordic.sv =====
// Pipelined rotation-mode CORDIC in degrees, one micro-rotation per stage,
// with quadrant fix-up on the output. Depends on s2c_pkg.
module s2c_cordic
    import s2c_pkg::*;
#(
    parameter int STAGES = 16
)
(
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [ZW-1:0] rem_in,
    input  logic [1:0]           quad_in,
    output logic signed [XW-1:0] cos_out,
    output logic signed [XW-1:0] sin_out
);

    logic signed [XW-1:0] x_reg [STAGES];
    logic signed [XW-1:0] y_reg [STAGES];
    logic signed [ZW-1:0] z_reg [STAGES];
    logic [1:0]           q_reg [STAGES];

    // One micro-rotation per register stage
    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        logic signed [XW-1:0] xp, yp, xs, ys, x_next, y_next;
        logic signed [ZW-1:0] zp, z_next;
        logic [1:0]           qp;

        if (i == 0) begin : g_first
            assign xp = CORDIC_GAIN;
            assign yp = '0;
            assign zp = rem_in;
            assign qp = quad_in;
        end else begin : g_rest
            assign xp = x_reg[i-1];
            assign yp = y_reg[i-1];
            assign zp = z_reg[i-1];
            assign qp = q_reg[i-1];
        end

        assign xs = xp >>> i;
        assign ys = yp >>> i;

        always_comb
        begin
            if (!zp[ZW-1]) begin
                x_next = xp - ys;
                y_next = yp + xs;
                z_next = zp - atan_deg(i);
            end else begin
                x_next = xp + ys;
                y_next = yp - xs;
                z_next = zp + atan_deg(i);
            end
        end

        always_ff @(posedge clk)
        begin
            if (en) begin
                x_reg[i] <= x_next;
                y_reg[i] <= y_next;
                z_reg[i] <= z_next;
                q_reg[i] <= qp;
            end
        end
    end

    // Swap and negate by quadrant
    always_comb
    begin
        case (q_reg[STAGES-1])
            2'd0: begin cos_out = x_reg[STAGES-1];  sin_out = y_reg[STAGES-1];  end
            2'd1: begin cos_out = -y_reg[STAGES-1]; sin_out = x_reg[STAGES-1];  end
            2'd2: begin cos_out = -x_reg[STAGES-1]; sin_out = -y_reg[STAGES-1]; end
            default: begin cos_out = y_reg[STAGES-1]; sin_out = -x_reg[STAGES-1]; end
        endcase
    end

endmodule

// ===== design/spherical_to_cartesian.sv =====
// Top level of the spherical to Cartesian converter: angle wrap, two CORDIC
// pipelines, two product stages and saturation. Depends on s2c_pkg, s2c_cordic.
//
// Usage:
//   Input transfers on the s_ channel carry two angles (degrees, 16 fraction
//   bits), a radius and, on s_tuser, a flag that the radius is given. Each
//   transfer yields one m_ transfer with x, y, z as saturated signed values
//   with FRAC_BITS fraction bits.
//   cfg_we/cfg_data write the convention bit: 0 azimuth/elevation, 1 polar.
//   Write it only while no item is in flight.
//   The pipeline runs through the angle wrap, quadrant split, one CORDIC
//   stage per micro-rotation, two multiplier stages and the output register.
//   Throughput is one item per cycle. The whole pipeline advances together:
//   when the output holds an untaken result, every stage holds and s_tready
//   drops; nothing is lost or repeated.
//   Reset clears all valid bits and sets the convention to azimuth/elevation.
module spherical_to_cartesian
    import s2c_pkg::*;
#(
    parameter int CORDIC_STAGES = 16,
    parameter int FRAC_BITS     = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,   // angle_a[25:0], angle_b[51:26], radius[83:52], zero
    input  logic        s_tuser,   // radius_given
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [95:0] m_tdata    // x_out[31:0], y_out[63:32], z_out[95:64]
);

    localparam logic signed [RAD_W-1:0] RAD_ONE = RAD_W'(1) << FRAC_BITS;
    localparam logic signed [P1_W-1:0]  RND1    = P1_W'(1) << 29;
    localparam logic signed [P2_W-1:0]  RND2    = P2_W'(1) << 29;
    localparam logic signed [LAT_W-1:0] SAT_HI  = LAT_W'(32'sh7FFFFFFF);
    localparam logic signed [LAT_W-1:0] SAT_LO  = -LAT_W'(33'sh080000000);

    conv_t conv_reg;
    logic  en;

    // Convention register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            conv_reg <= CONV_AZEL;
        else if (cfg_we)
            conv_reg <= conv_t'(cfg_data);
    end

    assign en       = !m_tvalid || m_tready;
    assign s_tready = en;

    // Wrap a signed angle into [0, 360)
    function automatic logic [MOD_W-1:0] wrap_ang(input logic signed [ANG_W-1:0] a);
        logic signed [ANG_W:0] t;
        t = {a[ANG_W-1], a};
        if (t < 0) begin
            t = t + ANG_FULL;
            if (t < 0)
                t = t + ANG_FULL;
        end else if (t >= ANG_FULL) begin
            t = t - ANG_FULL;
        end
        return t[MOD_W-1:0];
    endfunction

    // Split into quadrant and residue in [-45, 45)
    function automatic logic [ZW+1:0] split_ang(input logic [MOD_W-1:0] m);
        logic [1:0]           q;
        logic [MOD_W-1:0]     base;
        logic [MOD_W-1:0]     r;
        logic signed [ZW-1:0] rem;
        if (m >= ANG_3QUART) begin q = 2'd3; base = ANG_3QUART; end
        else if (m >= ANG_HALF) begin q = 2'd2; base = ANG_HALF; end
        else if (m >= ANG_QUARTER) begin q = 2'd1; base = ANG_QUARTER; end
        else begin q = 2'd0; base = '0; end
        r = m - base;
        if (r >= ANG_EIGHTH) begin
            rem = ZW'(r) - ZW'(ANG_QUARTER);
            q   = q + 2'd1;
        end else begin
            rem = ZW'(r);
        end
        return {q, rem};
    endfunction

    // Stage 1: accept and wrap
    logic                    v1_reg;
    logic [MOD_W-1:0]        ma1_reg, mb1_reg;
    logic signed [RAD_W-1:0] rad1_reg;
    logic                    giv1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v1_reg <= 1'b0;
        else if (en)
            v1_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            ma1_reg  <= wrap_ang(s_tdata[25:0]);
            mb1_reg  <= wrap_ang(s_tdata[51:26]);
            rad1_reg <= s_tdata[83:52];
            giv1_reg <= s_tuser;
        end
    end

    // Stage 2: quadrant and residue
    logic                    v2_reg;
    logic [1:0]              qa2_reg, qb2_reg;
    logic signed [ZW-1:0]    ra2_reg, rb2_reg;
    logic signed [RAD_W-1:0] rad2_reg;
    logic                    giv2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v2_reg <= 1'b0;
        else if (en)
            v2_reg <= v1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            {qa2_reg, ra2_reg} <= split_ang(ma1_reg);
            {qb2_reg, rb2_reg} <= split_ang(mb1_reg);
            rad2_reg <= rad1_reg;
            giv2_reg <= giv1_reg;
        end
    end

    // CORDIC pipelines
    logic signed [XW-1:0] ca, sa, cb, sb;

    s2c_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_a (
        .clk     (clk),
        .en      (en),
        .rem_in  (ra2_reg),
        .quad_in (qa2_reg),
        .cos_out (ca),
        .sin_out (sa)
    );

    s2c_cordic #(.STAGES(CORDIC_STAGES)) u_cordic_b (
        .clk     (clk),
        .en      (en),
        .rem_in  (rb2_reg),
        .quad_in (qb2_reg),
        .cos_out (cb),
        .sin_out (sb)
    );

    // Delay valid and radius alongside the CORDIC stages
    logic                    vd_reg   [CORDIC_STAGES];
    logic signed [RAD_W-1:0] radd_reg [CORDIC_STAGES];
    logic                    givd_reg [CORDIC_STAGES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int i = 0; i < CORDIC_STAGES; i++)
                vd_reg[i] <= 1'b0;
        end else if (en) begin
            vd_reg[0] <= v2_reg;
            for (int i = 1; i < CORDIC_STAGES; i++)
                vd_reg[i] <= vd_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            radd_reg[0] <= rad2_reg;
            givd_reg[0] <= giv2_reg;
            for (int i = 1; i < CORDIC_STAGES; i++) begin
                radd_reg[i] <= radd_reg[i-1];
                givd_reg[i] <= givd_reg[i-1];
            end
        end
    end

    // Stage M1: radius select, lateral and z products
    logic signed [RAD_W-1:0] r_sel;
    logic signed [XW-1:0]    lat_trig, z_trig;
    logic signed [P1_W-1:0]  lat_prod, z_prod;
    logic                    vm1_reg;
    logic signed [LAT_W-1:0] lat_reg, zm1_reg;
    logic signed [XW-1:0]    cam1_reg, sam1_reg;

    always_comb
    begin
        r_sel = RAD_ONE;
        if (conv_reg == CONV_AZEL) begin
            if (givd_reg[CORDIC_STAGES-1] && radd_reg[CORDIC_STAGES-1] > 0)
                r_sel = radd_reg[CORDIC_STAGES-1];
            lat_trig = cb;
            z_trig   = sb;
        end else begin
            if (givd_reg[CORDIC_STAGES-1])
                r_sel = radd_reg[CORDIC_STAGES-1];
            lat_trig = sb;
            z_trig   = cb;
        end
        lat_prod = P1_W'(r_sel) * P1_W'(lat_trig) + RND1;
        z_prod   = P1_W'(r_sel) * P1_W'(z_trig) + RND1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vm1_reg <= 1'b0;
        else if (en)
            vm1_reg <= vd_reg[CORDIC_STAGES-1];
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            lat_reg  <= lat_prod[P1_W-1:30];
            zm1_reg  <= z_prod[P1_W-1:30];
            cam1_reg <= ca;
            sam1_reg <= sa;
        end
    end

    // Stage M2: x and y products
    logic                    vm2_reg;
    logic signed [P2_W-1:0]  xp_reg, yp_reg;
    logic signed [LAT_W-1:0] zm2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vm2_reg <= 1'b0;
        else if (en)
            vm2_reg <= vm1_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            xp_reg  <= P2_W'(lat_reg) * P2_W'(cam1_reg) + RND2;
            yp_reg  <= P2_W'(lat_reg) * P2_W'(sam1_reg) + RND2;
            zm2_reg <= zm1_reg;
        end
    end

    // Output stage: round and saturate
    function automatic logic [COORD_W-1:0] sat_coord(input logic signed [PR_W-1:0] v);
        if (v > PR_W'(SAT_HI))
            return 32'h7FFFFFFF;
        else if (v < PR_W'(SAT_LO))
            return 32'h80000000;
        else
            return v[COORD_W-1:0];
    endfunction

    logic        out_v_reg;
    logic [95:0] out_d_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_v_reg <= 1'b0;
        else if (en)
            out_v_reg <= vm2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            out_d_reg[31:0]  <= sat_coord(xp_reg[P2_W-1:30]);
            out_d_reg[63:32] <= sat_coord(yp_reg[P2_W-1:30]);
            out_d_reg[95:64] <= sat_coord(PR_W'(zm2_reg));
        end
    end

    assign m_tvalid = out_v_reg;
    assign m_tdata  = out_d_reg;

    // Accepted input shows up in the first stage
    a_accept_lands: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> v1_reg)
        else $error("accepted transfer missing from wrap stage");

    // Stall freezes the valid chain
    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !en |=> ($stable(v1_reg) && $stable(v2_reg) && $stable(vm1_reg)
                 && $stable(vm2_reg)))
        else $error("pipeline moved during stall");

    // Wrapped angles stay below a full turn
    a_wrap_range: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg |-> (ma1_reg < ANG_FULL[MOD_W-1:0] && mb1_reg < ANG_FULL[MOD_W-1:0]))
        else $error("angle wrap out of range");

    // Residues stay within one eighth turn
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        v2_reg |-> (ra2_reg >= -$signed(ZW'(ANG_EIGHTH)) && ra2_reg < $signed(ZW'(ANG_EIGHTH))
                    && rb2_reg >= -$signed(ZW'(ANG_EIGHTH))
                    && rb2_reg < $signed(ZW'(ANG_EIGHTH))))
        else $error("quadrant residue out of range");

endmodule

// ===== bench/s2c_checker.sv =====
// Checker for the spherical to Cartesian converter: watches both stream
// channels, predicts each point and compares. Depends on s2c_pkg.
module s2c_checker
    import s2c_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_data,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [87:0] s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [95:0] m_tdata,
    output int          errors,
    output int          pending,
    output int          points_seen
);

    localparam int STAGES = 16;
    localparam int FRAC   = 16;

    localparam longint FULL_TURN = 23592960;
    localparam longint QUARTER   = 5898240;
    localparam longint EIGHTH    = 2949120;
    localparam longint GAIN_Q30  = 652032874;

    conv_t        conv_mode;
    logic [95:0]  point_queue[$];

    function automatic longint round_q30(longint a, longint b);
        return (a * b + 64'sd536870912) >>> 30;
    endfunction

    function automatic longint clip32(longint v);
        if (v > 64'sd2147483647)
            return 64'sd2147483647;
        if (v < -64'sd2147483648)
            return -64'sd2147483648;
        return v;
    endfunction

    // Cosine and sine of an angle in 2^-16 degree units, both Q30
    function automatic void degree_sincos(input longint ang, output longint c,
                                          output longint s);
        longint m, q, rem, x, y, z, xn, yn;
        m = ang % FULL_TURN;
        if (m < 0)
            m += FULL_TURN;
        q = m / QUARTER;
        rem = m - q * QUARTER;
        if (rem >= EIGHTH)
        begin
            rem -= QUARTER;
            q += 1;
        end
        q = q & 3;
        x = GAIN_Q30;
        y = 0;
        z = rem;
        for (int i = 0; i < STAGES; i++)
        begin
            if (z >= 0)
            begin
                xn = x - (y >>> i);
                yn = y + (x >>> i);
                z -= longint'(atan_deg(i));
            end
            else
            begin
                xn = x + (y >>> i);
                yn = y - (x >>> i);
                z += longint'(atan_deg(i));
            end
            x = xn;
            y = yn;
        end
        case (q)
            0: begin c = x;  s = y;  end
            1: begin c = -y; s = x;  end
            2: begin c = -x; s = -y; end
            default: begin c = y; s = -x; end
        endcase
    endfunction

    function automatic logic [95:0] predict_point(logic [87:0] d, logic given);
        longint a, b, rin, r, ca, sa, cb, sb, lat, zo;
        logic [31:0] xo, yo, zz;
        a = longint'($signed(d[25:0]));
        b = longint'($signed(d[51:26]));
        rin = longint'($signed(d[83:52]));
        r = longint'(1) << FRAC;
        degree_sincos(a, ca, sa);
        degree_sincos(b, cb, sb);
        if (conv_mode == CONV_AZEL)
        begin
            if (given && rin > 0)
                r = rin;
            lat = round_q30(r, cb);
            zo = round_q30(r, sb);
        end
        else
        begin
            if (given)
                r = rin;
            lat = round_q30(r, sb);
            zo = round_q30(r, cb);
        end
        xo = 32'(clip32(round_q30(lat, ca)));
        yo = 32'(clip32(round_q30(lat, sa)));
        zz = 32'(clip32(zo));
        return {zz, yo, xo};
    endfunction

    // Track the convention, queue predictions, compare each output transfer
    always @(posedge clk or negedge rst_n)
    begin
        logic [95:0] want;
        if (!rst_n)
        begin
            conv_mode <= CONV_AZEL;
            errors = 0;
            points_seen = 0;
            point_queue.delete();
        end
        else
        begin
            if (s_tvalid && s_tready)
                point_queue.push_back(predict_point(s_tdata, s_tuser));
            if (m_tvalid && m_tready)
            begin
                points_seen++;
                if (point_queue.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected point %h", $time, m_tdata);
                end
                else
                begin
                    want = point_queue.pop_front();
                    for (int f = 0; f < 3; f++)
                        if (m_tdata[f*32 +: 32] !== want[f*32 +: 32])
                        begin
                            errors++;
                            $display("%0t: coord %0d expected %h actual %h",
                                     $time, f, want[f*32 +: 32], m_tdata[f*32 +: 32]);
                        end
                end
            end
            if (cfg_we)
                conv_mode <= conv_t'(cfg_data);
        end
        pending = point_queue.size();
    end

endmodule

// ===== bench/tb_spherical_to_cartesian.sv =====
// Testbench top for the spherical to Cartesian converter: drives stimulus,
// idling and convention changes, gives the verdict. Depends on s2c_pkg, s2c_checker.
module tb_spherical_to_cartesian
    import s2c_pkg::*;
();

    localparam int LATENCY = 21;
    localparam int LIMIT   = 400000;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_data;
    logic        s_tvalid;
    logic        s_tready;
    logic [87:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [95:0] m_tdata;
    int          errors;
    int          pending;
    int          points_seen;
    int          send_idle_pct;
    int          recv_stall_pct;
    bit          hold_off;
    int          cycles;

    spherical_to_cartesian i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg_we  (cfg_we),
        .cfg_data(cfg_data),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    s2c_checker i_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .errors     (errors),
        .pending    (pending),
        .points_seen(points_seen)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Watchdog on a cycle count
    initial
    begin
        cycles = 0;
        forever
        begin
            @(posedge clk);
            cycles++;
            if (cycles > LIMIT)
            begin
                $display("Regression FAIL");
                $finish;
            end
        end
    end

    // Receiver: random stall, or a long hold-off on request
    always @(posedge clk)
    begin
        if (hold_off)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic logic [25:0] pick_angle();
        case ($urandom_range(5))
            0: return 26'($signed(-23592960));
            1: return 26'd23592960;
            2: return 26'($urandom_range(16) * 1474560);
            3: return 26'($urandom);
            default: return 26'($signed($urandom_range(47185920)) - 23592960);
        endcase
    endfunction

    function automatic logic [31:0] pick_radius();
        case ($urandom_range(4))
            0: return 32'h7fffffff;
            1: return 32'h80000000;
            2: return 32'($urandom_range(65536 * 200));
            default: return $urandom;
        endcase
    endfunction

    // Offer one item and hold it until the transfer
    task automatic send_point(logic [25:0] a, logic [25:0] b, logic [31:0] r, logic given);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {4'b0, r, b, a};
        s_tuser <= given;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic go_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY + 4) @(posedge clk);
    endtask

    task automatic set_convention(conv_t c);
        go_idle();
        cfg_we <= 1'b1;
        cfg_data <= c;
        @(posedge clk);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_run(int n);
        for (int k = 0; k < n; k++)
            send_point(pick_angle(), pick_angle(), pick_radius(), 1'($urandom_range(1)));
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        m_tready = 1'b0;
        hold_off = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: extremes, quadrant edges, radius special cases, both conventions
        for (int c = 0; c < 2; c++)
        begin
            set_convention(conv_t'(c));
            send_point(26'($signed(-23592960)), 26'd23592960, 32'h7fffffff, 1'b1);
            send_point(26'd5898240, 26'd2949120, 32'h80000000, 1'b1);
            send_point(26'd2949119, 26'($signed(-2949120)), 32'd0, 1'b1);
            send_point(26'd11796480, 26'd17694720, 32'd0, 1'b0);
            send_point(26'h1ffffff, 26'h2000000, 32'hffff0000, 1'b1);
            send_point(26'd0, 26'd0, 32'h00020000, 1'b1);
            send_point(26'd8847360, 26'd14745600, 32'h7fffffff, 1'b0);
            send_point(26'h3ffffff, 26'h0, 32'h00000001, 1'b1);
        end

        // Random phases with different idling
        for (int ph = 0; ph < 8; ph++)
        begin
            set_convention(conv_t'(ph & 1));
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 88; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 88; end
                default: begin send_idle_pct = 37; recv_stall_pct = 37; end
            endcase
            random_run(70);
        end

        // Long receiver hold-off while the sender keeps offering
        send_idle_pct = 0;
        recv_stall_pct = 0;
        fork
            begin
                hold_off = 1'b1;
                repeat (3 * LATENCY) @(posedge clk);
                hold_off = 1'b0;
            end
            random_run(40);
        join
        go_idle();

        $display("Covered %0d points over both conventions, angle and radius extremes,",
                 points_seen);
        $display("sender gaps, receiver stalls and a full-pipeline back-pressure stretch.");
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== files.f =====
design/s2c_pkg.sv
design/s2c_cordic.sv
design/spherical_to_cartesian.sv
bench/s2c_checker.sv
bench/tb_spherical_to_cartesian.sv
